// ===== rtl/z85_rotating_alphabet_codec_unit_defines.svh =====
// Assertion macros shared by the codec RTL files.
// Expects signals named clk and rst in the module that uses them.
`ifndef Z85_ROTATING_ALPHABET_CODEC_UNIT_DEFINES_SVH
`define Z85_ROTATING_ALPHABET_CODEC_UNIT_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define ZRAC_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle, outside reset.
`define ZRAC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/zrac_pkg.sv =====
// Shared types, constants and functions of the rotating-alphabet Z85 codec.
// No dependencies; the codec modules refer to it by scoped names.
package zrac_pkg;

  localparam int RADIX        = 85;
  localparam int DIGIT_W      = 7;
  localparam int GROUP_DIGITS = 5;
  localparam int GROUP_BYTES  = 4;
  localparam int REG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 7;

  // Reciprocal of 85 scaled by 2^38; exact quotient for every 32-bit value.
  localparam logic [31:0] RECIP_85   = 32'hC0C0C0C1;
  localparam int          RECIP_SHIFT = 38;

  // Group queue; depth is a power of two so the pointers wrap by themselves.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [8*RADIX-1:0] ALPHABET = {
    "0123456789abcdefghijklmnopqrstuvwxyz",
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
    ".-:+=^!/*?&<>()[]{}@%$#"
  };

  typedef logic [DIGIT_W-1:0]     digit_t;
  typedef logic [QUEUE_PTR_W-1:0] qptr_t;
  typedef logic [QUEUE_CNT_W-1:0] qcnt_t;

  localparam qcnt_t QUEUE_FULL = qcnt_t'(QUEUE_DEPTH);

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_MODE = 1'd0,
    REG_STEP = 1'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_BUSY,
    CONV_FULL
  } conv_state_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  count;
    digit_t      offset;
    logic        bad;
  } job_t;

  typedef struct packed {
    logic [31:0]                     word;
    digit_t [GROUP_DIGITS-1:0]       digits;
    digit_t                          offset;
    logic                            bad;
    logic                            encode;
  } group_t;

  typedef struct packed {
    logic   found;
    digit_t index;
  } lookup_t;

  function automatic digit_t mod85(input logic [8:0] v);
    logic [8:0] t;
    t = v;
    if (t >= 9'(4 * RADIX)) t = t - 9'(4 * RADIX);
    if (t >= 9'(2 * RADIX)) t = t - 9'(2 * RADIX);
    if (t >= 9'(RADIX))     t = t - 9'(RADIX);
    return t[DIGIT_W-1:0];
  endfunction

  function automatic logic [7:0] alpha_char(input digit_t idx);
    logic [7:0] c;
    c = 8'h00;
    if (int'(idx) < RADIX) c = ALPHABET[8 * (RADIX - 1 - int'(idx)) +: 8];
    return c;
  endfunction

  function automatic lookup_t char_lookup(input logic [7:0] c);
    lookup_t res;
    res = '0;
    for (int j = 0; j < RADIX; j++) begin
      if (ALPHABET[8 * (RADIX - 1 - j) +: 8] == c) begin
        res.found = 1'b1;
        res.index = DIGIT_W'(j);
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/zrac_ifs.sv =====
// Valid/ready stream interfaces for the codec's item and result channels.
// Standalone; widths follow the item and result fields.
interface zrac_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface zrac_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       bad_char;

  modport source (output valid, output out_byte, output out_last, output bad_char,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input bad_char,
                  output ready);
endinterface

// ===== rtl/z85_rotating_alphabet_codec_unit.sv =====
// Top level of the rotating-alphabet Z85 codec: configuration registers,
// front end, group queue, radix converter and emitter. Depends on zrac_pkg,
// zrac_ifs, zrac_fifo, zrac_front, zrac_conv and zrac_emit.
//
// One byte per item goes in on item_chan, results come out on result_chan.
// Encode packs four bytes (zero-padded on in_last) into five Z85 characters
// from an alphabet rotated by a running offset; decode turns five characters
// (missing ones count as digit zero on in_last) into four bytes and flags
// characters outside the alphabet on bad_char. The front end takes one item
// per cycle while the two-entry group queue has room. In encode the radix
// converter produces one base-85 digit per cycle; characters then leave one
// per cycle while result_chan is ready. In decode the input port sets the
// rate at one character per cycle, and the converter pads a short final
// group with zero digits. The first result of a group passes through the
// group queue, the converter and the emitter's output register. Write mode
// and rotate_step only while no results are outstanding; writing mode drops
// a partial group.

module z85_rotating_alphabet_codec_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [zrac_pkg::REG_INDEX_W-1:0]   wr_index,
  input  logic [zrac_pkg::CFG_DATA_W-1:0]    wr_data,
  zrac_item_if.sink                          item_chan,
  zrac_result_if.source                      result_chan
);

  zrac_pkg::mode_t  mode;
  zrac_pkg::digit_t step85;
  zrac_pkg::digit_t step5;
  logic             mode_write;

  logic             push_valid;
  zrac_pkg::job_t   push_data;
  logic             push_ready;
  logic             pop_valid;
  zrac_pkg::job_t   pop_data;
  logic             pop_ready;
  logic             group_valid;
  zrac_pkg::group_t group;
  logic             group_ready;

  assign mode_write = wr_en & (wr_index == zrac_pkg::REG_MODE);
  assign step5      = zrac_pkg::mod85({step85, 2'b00} + 9'(step85));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= zrac_pkg::MODE_ENCODE;
      step85 <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        zrac_pkg::REG_MODE: mode   <= zrac_pkg::mode_t'(wr_data[0]);
        zrac_pkg::REG_STEP: step85 <= zrac_pkg::mod85(9'(wr_data));
        default:            mode   <= mode;
      endcase
    end
  end

  zrac_front u_front (
    .clk       (clk),
    .rst       (rst),
    .clear     (mode_write),
    .mode      (mode),
    .step85    (step85),
    .step5     (step5),
    .item      (item_chan),
    .job_valid (push_valid),
    .job       (push_data),
    .job_ready (push_ready)
  );

  zrac_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  zrac_conv u_conv (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .job_valid   (pop_valid),
    .job         (pop_data),
    .job_ready   (pop_ready),
    .group_valid (group_valid),
    .group       (group),
    .group_ready (group_ready)
  );

  zrac_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .step85      (step85),
    .group_valid (group_valid),
    .group       (group),
    .group_ready (group_ready),
    .result      (result_chan)
  );

endmodule

// ===== rtl/zrac_fifo.sv =====
// Two-entry queue of group jobs between the front end and the converter.
// Depends on zrac_pkg and the assertion macro header.
`include "z85_rotating_alphabet_codec_unit_defines.svh"

module zrac_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  zrac_pkg::job_t push_data,
  output logic          push_ready,
  output logic          pop_valid,
  output zrac_pkg::job_t pop_data,
  input  logic          pop_ready
);

  zrac_pkg::job_t  entries [zrac_pkg::QUEUE_DEPTH];
  zrac_pkg::qptr_t wr_ptr;
  zrac_pkg::qptr_t rd_ptr;
  zrac_pkg::qcnt_t fill;
  logic            push;
  logic            pop;

  assign push_ready = (fill != zrac_pkg::QUEUE_FULL);
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + zrac_pkg::qptr_t'(1);
      if (pop)  rd_ptr <= rd_ptr + zrac_pkg::qptr_t'(1);
      unique case ({push, pop})
        2'b10:   fill <= fill + zrac_pkg::qcnt_t'(1);
        2'b01:   fill <= fill - zrac_pkg::qcnt_t'(1);
        default: fill <= fill;
      endcase
    end
  end

  `ZRAC_ASSERT_IMPLIES(a_no_overflow, push_valid, push_ready, "group pushed into full queue")

endmodule

// ===== rtl/zrac_front.sv =====
// Front end: accepts items, collects groups, tracks the rotation offset.
// Depends on zrac_pkg, zrac_ifs and the assertion macro header.
`include "z85_rotating_alphabet_codec_unit_defines.svh"

module zrac_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  zrac_pkg::mode_t   mode,
  input  zrac_pkg::digit_t  step85,
  input  zrac_pkg::digit_t  step5,
  zrac_item_if.sink         item,
  output logic              job_valid,
  output zrac_pkg::job_t    job,
  input  logic              job_ready
);

  logic [31:0]         group_value;
  logic [2:0]          group_count;
  zrac_pkg::digit_t    rotation_offset;
  logic                group_bad;

  logic                accept;
  logic [2:0]          count_inc;
  logic [31:0]         enc_value;
  logic [31:0]         dec_value;
  logic [31:0]         acc_value;
  logic [31:0]         padded;
  zrac_pkg::lookup_t   lk;
  zrac_pkg::digit_t    pos;
  zrac_pkg::digit_t    offset_adv;
  logic                bad_acc;
  logic                group_done;

  assign item.ready = job_ready;
  assign accept     = item.valid & item.ready;
  assign count_inc  = group_count + 3'd1;
  assign enc_value  = {group_value[23:0], item.in_byte};
  assign lk         = zrac_pkg::char_lookup(item.in_byte);
  assign pos        = lk.found ? zrac_pkg::mod85(9'(lk.index) + 9'(rotation_offset)) : '0;
  assign dec_value  = (group_value << 6) + (group_value << 4) + (group_value << 2)
                    + group_value + 32'(pos);

  always_comb begin
    unique case (count_inc)
      3'd1:    padded = enc_value << 24;
      3'd2:    padded = enc_value << 16;
      3'd3:    padded = enc_value << 8;
      default: padded = enc_value;
    endcase
  end

  always_comb begin
    unique case (mode)
      zrac_pkg::MODE_ENCODE: begin
        group_done = (count_inc == 3'(zrac_pkg::GROUP_BYTES)) | item.in_last;
        offset_adv = group_done ? zrac_pkg::mod85(9'(rotation_offset) + 9'(step5))
                                : rotation_offset;
        acc_value  = enc_value;
        bad_acc    = 1'b0;
      end
      zrac_pkg::MODE_DECODE: begin
        group_done = (count_inc == 3'(zrac_pkg::GROUP_DIGITS)) | item.in_last;
        offset_adv = zrac_pkg::mod85(9'(rotation_offset) + 9'(step85));
        acc_value  = dec_value;
        bad_acc    = group_bad | ~lk.found;
      end
    endcase
  end

  always_comb begin
    job.value  = (mode == zrac_pkg::MODE_ENCODE) ? padded : dec_value;
    job.count  = count_inc;
    job.offset = rotation_offset;
    job.bad    = bad_acc;
  end

  assign job_valid = accept & group_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_value     <= '0;
      group_count     <= '0;
      group_bad       <= 1'b0;
      rotation_offset <= '0;
    end else begin
      if (accept) begin
        rotation_offset <= item.in_last ? '0 : offset_adv;
      end
      if (clear || (accept && group_done)) begin
        group_value <= '0;
        group_count <= '0;
        group_bad   <= 1'b0;
      end else if (accept) begin
        group_value <= acc_value;
        group_count <= count_inc;
        group_bad   <= bad_acc;
      end
    end
  end

  `ZRAC_ASSERT_HOLDS(a_offset_range, rotation_offset < zrac_pkg::digit_t'(zrac_pkg::RADIX), "rotation offset out of range")

endmodule

// ===== rtl/zrac_conv.sv =====
// Radix converter: splits encode groups into base-85 digits one per cycle,
// pads short decode groups by 85 one step per cycle. Depends on zrac_pkg.
`include "z85_rotating_alphabet_codec_unit_defines.svh"

module zrac_conv (
  input  logic              clk,
  input  logic              rst,
  input  zrac_pkg::mode_t   mode,
  input  logic              job_valid,
  input  zrac_pkg::job_t    job,
  output logic              job_ready,
  output logic              group_valid,
  output zrac_pkg::group_t  group,
  input  logic              group_ready
);

  zrac_pkg::conv_state_t                      state;
  zrac_pkg::conv_state_t                      state_next;
  logic [2:0]                                 steps;
  logic [31:0]                                cur;
  zrac_pkg::digit_t [zrac_pkg::GROUP_DIGITS-1:0] digits;
  zrac_pkg::digit_t                           offset;
  logic                                       bad;
  logic                                       encode;

  logic                  load;
  logic [2:0]            load_steps;
  zrac_pkg::conv_state_t load_state;
  logic [63:0]           prod;
  logic [31:0]           quot;
  logic [13:0]           qlo85;
  zrac_pkg::digit_t      remainder;
  logic [31:0]           times85;

  assign prod      = 64'(cur) * 64'(zrac_pkg::RECIP_85);
  assign quot      = 32'(prod[63:zrac_pkg::RECIP_SHIFT]);
  assign qlo85     = 14'(quot[zrac_pkg::DIGIT_W-1:0]) * 14'(zrac_pkg::RADIX);
  assign remainder = cur[zrac_pkg::DIGIT_W-1:0] - qlo85[zrac_pkg::DIGIT_W-1:0];
  assign times85   = (cur << 6) + (cur << 4) + (cur << 2) + cur;

  assign load_steps = (mode == zrac_pkg::MODE_ENCODE) ? 3'(zrac_pkg::GROUP_DIGITS)
                                                      : 3'(zrac_pkg::GROUP_DIGITS) - job.count;
  assign load_state = (load_steps == '0) ? zrac_pkg::CONV_FULL : zrac_pkg::CONV_BUSY;
  assign load       = job_valid & job_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      zrac_pkg::CONV_IDLE: begin
        if (job_valid) state_next = load_state;
      end
      zrac_pkg::CONV_BUSY: begin
        if (steps == 3'd1) state_next = zrac_pkg::CONV_FULL;
      end
      zrac_pkg::CONV_FULL: begin
        if (group_ready) state_next = job_valid ? load_state : zrac_pkg::CONV_IDLE;
      end
      default: state_next = zrac_pkg::CONV_IDLE;
    endcase
  end

  always_comb begin
    job_ready   = (state == zrac_pkg::CONV_IDLE)
                | ((state == zrac_pkg::CONV_FULL) & group_ready);
    group_valid = (state == zrac_pkg::CONV_FULL);
    group       = '{word: cur, digits: digits, offset: offset, bad: bad, encode: encode};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zrac_pkg::CONV_IDLE;
      steps <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        steps <= load_steps;
      end else if (state == zrac_pkg::CONV_BUSY) begin
        steps <= steps - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur    <= job.value;
      offset <= job.offset;
      bad    <= job.bad;
      encode <= (mode == zrac_pkg::MODE_ENCODE);
    end else if (state == zrac_pkg::CONV_BUSY) begin
      if (encode) begin
        cur    <= quot;
        digits <= {remainder, digits[zrac_pkg::GROUP_DIGITS-1:1]};
      end else begin
        cur <= times85;
      end
    end
  end

  `ZRAC_ASSERT_IMPLIES(a_busy_has_steps, state == zrac_pkg::CONV_BUSY, steps != '0, "converter busy with no steps left")

endmodule

// ===== rtl/zrac_emit.sv =====
// Emitter: issues one character or byte per cycle from a converted group
// into the output register when it is free. Needs zrac_pkg and zrac_ifs.
`include "z85_rotating_alphabet_codec_unit_defines.svh"

module zrac_emit (
  input  logic              clk,
  input  logic              rst,
  input  zrac_pkg::digit_t  step85,
  input  logic              group_valid,
  input  zrac_pkg::group_t  group,
  output logic              group_ready,
  zrac_result_if.source     result
);

  logic                                       active;
  logic [2:0]                                 index;
  logic [31:0]                                word;
  zrac_pkg::digit_t [zrac_pkg::GROUP_DIGITS-1:0] digits;
  zrac_pkg::digit_t                           offset;
  logic                                       bad;
  logic                                       encode;
  logic                                       out_valid;
  logic [7:0]                                 out_byte;
  logic                                       out_last;
  logic                                       out_bad;

  logic [2:0]        last_idx;
  logic              issue;
  logic              final_issue;
  logic              take;
  zrac_pkg::digit_t  dig;
  logic [7:0]        rot_sum;
  zrac_pkg::digit_t  rot_idx;
  logic [7:0]        byte_next;
  zrac_pkg::digit_t  offset_adv;

  assign last_idx    = encode ? 3'(zrac_pkg::GROUP_DIGITS - 1) : 3'(zrac_pkg::GROUP_BYTES - 1);
  assign issue       = active & (~out_valid | result.ready);
  assign final_issue = issue & (index == last_idx);
  assign group_ready = ~active | final_issue;
  assign take        = group_valid & group_ready;

  assign dig        = digits[zrac_pkg::GROUP_DIGITS-1];
  assign rot_sum    = {1'b0, dig} + 8'(zrac_pkg::RADIX) - {1'b0, offset};
  assign rot_idx    = (dig >= offset) ? (dig - offset) : rot_sum[zrac_pkg::DIGIT_W-1:0];
  assign byte_next  = encode ? zrac_pkg::alpha_char(rot_idx) : word[31:24];
  assign offset_adv = zrac_pkg::mod85(9'(offset) + 9'(step85));

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;
  assign result.out_last = out_last;
  assign result.bad_char = out_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      index     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        active <= 1'b1;
        index  <= '0;
      end else if (final_issue) begin
        active <= 1'b0;
      end else if (issue) begin
        index <= index + 3'd1;
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_byte <= byte_next;
      out_last <= (index == last_idx);
      out_bad  <= bad & ~encode;
    end
    if (take) begin
      word   <= group.word;
      digits <= group.digits;
      offset <= group.offset;
      bad    <= group.bad;
      encode <= group.encode;
    end else if (issue) begin
      word   <= word << 8;
      digits <= {digits[zrac_pkg::GROUP_DIGITS-2:0], zrac_pkg::digit_t'(0)};
      offset <= offset_adv;
    end
  end

  `ZRAC_ASSERT_IMPLIES(a_index_bound, active, index <= last_idx, "emit index past end of group")

endmodule

// ===== dv/z85_rotating_alphabet_codec_unit_tb.sv =====
// Self-checking testbench for the rotating-alphabet Z85 codec unit: a directed
// table followed by random encode/decode streams, checked against an in-bench
// model or known table values. Depends on zrac_pkg, zrac_ifs and the codec RTL.
module z85_rotating_alphabet_codec_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_LEN   = 11;
  localparam int SETTLE      = 30;
  localparam int LONG_HOLD   = 400;
  localparam int LONG_PHASE  = 80;
  localparam int ITEM_TARGET = 470;
  localparam int CYCLE_LIMIT = 600000;

  localparam logic [8*zrac_pkg::RADIX-1:0] Z85_SET = {
    "0123456789abcdefghijklmnopqrstuvwxyz",
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
    ".-:+=^!/*?&<>()[]{}@%$#"
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       bad_char;
  } codec_out_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_SET_MODE,
    ROW_SET_STEP
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  val;
    logic        last;
    logic [2:0]  n_known;
    logic [39:0] known;
    logic        known_bad;
  } plan_row_t;

  localparam int PLAN_LEN = 30;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_ITEM,     8'h00, 1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     8'h00, 1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     8'h00, 1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     8'h00, 1'b0, 3'd5, "00000",         1'b0},
    '{ROW_ITEM,     8'hFF, 1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     8'hFF, 1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     8'hFF, 1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     8'hFF, 1'b1, 3'd5, "%nSc0",         1'b0},
    '{ROW_ITEM,     8'h80, 1'b1, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     8'h12, 1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     8'h34, 1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     8'h56, 1'b1, 3'd0, 40'd0,           1'b0},
    '{ROW_SET_STEP, 8'd84, 1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     8'hAB, 1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     8'hCD, 1'b1, 3'd0, 40'd0,           1'b0},
    '{ROW_SET_STEP, 8'd127, 1'b0, 3'd0, 40'd0,          1'b0},
    '{ROW_ITEM,     8'h7F, 1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     8'h80, 1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_SET_MODE, 8'd1,  1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_SET_STEP, 8'd0,  1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     "%",   1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     "n",   1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     "S",   1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     "c",   1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     "0",   1'b0, 3'd4, 40'h00FFFFFFFF,  1'b0},
    '{ROW_ITEM,     8'h20, 1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     8'hFF, 1'b1, 3'd4, 40'h0000000000,  1'b1},
    '{ROW_SET_STEP, 8'd84, 1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     "#",   1'b0, 3'd0, 40'd0,           1'b0},
    '{ROW_ITEM,     "#",   1'b1, 3'd0, 40'd0,           1'b0}
  };

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             wr_en;
  logic [zrac_pkg::REG_INDEX_W-1:0] wr_index;
  logic [zrac_pkg::CFG_DATA_W-1:0]  wr_data;

  zrac_item_if   item_chan ();
  zrac_result_if result_chan ();

  z85_rotating_alphabet_codec_unit dut (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .item_chan   (item_chan),
    .result_chan (result_chan)
  );

  zrac_pkg::mode_t cur_mode;
  logic [6:0]      cur_step;
  logic [31:0]     acc_value;
  int              acc_count;
  int              rot_offset;
  logic            acc_bad;

  codec_out_t  owed_codes[$];
  int          failures;
  int          items_sent;
  int          cycle_count;
  bit          quiet;
  bit          long_hold_req;

  always #5 clk = ~clk;

  function automatic logic [7:0] z85_char(input int i);
    return Z85_SET[8*(zrac_pkg::RADIX-1-i) +: 8];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void drop_group();
    acc_value = '0;
    acc_count = 0;
    acc_bad   = 1'b0;
  endfunction

  function automatic void advance_rotation();
    rot_offset = (rot_offset + int'(cur_step) % zrac_pkg::RADIX) % zrac_pkg::RADIX;
  endfunction

  // Advance the codec state by one byte; queue its output when keep is set.
  function automatic void z85_translate(input logic [7:0] b, input logic l, input bit keep);
    logic [31:0] v;
    int          digit [zrac_pkg::GROUP_DIGITS];
    int          c;
    int          j;
    int          pos;
    bit          found;
    codec_out_t  r;
    if (cur_mode == zrac_pkg::MODE_ENCODE) begin
      acc_value = {acc_value[23:0], b};
      acc_count = acc_count + 1;
      if (acc_count >= zrac_pkg::GROUP_BYTES || l) begin
        v = acc_value;
        for (c = acc_count; c < zrac_pkg::GROUP_BYTES; c++) v = v << 8;
        for (j = zrac_pkg::GROUP_DIGITS - 1; j >= 0; j--) begin
          digit[j] = int'(v % 32'd85);
          v = v / 32'd85;
        end
        for (j = 0; j < zrac_pkg::GROUP_DIGITS; j++) begin
          r.out_byte = z85_char((digit[j] + zrac_pkg::RADIX - rot_offset) % zrac_pkg::RADIX);
          r.out_last = (j == zrac_pkg::GROUP_DIGITS - 1);
          r.bad_char = 1'b0;
          if (keep) owed_codes.push_back(r);
          advance_rotation();
        end
        drop_group();
      end
    end else begin
      pos = 0;
      found = 1'b0;
      for (j = 0; j < zrac_pkg::RADIX; j++) begin
        if (!found && z85_char(j) == b) begin
          pos = (j + rot_offset) % zrac_pkg::RADIX;
          found = 1'b1;
        end
      end
      if (!found) acc_bad = 1'b1;
      acc_value = acc_value * 32'd85 + 32'(pos);
      acc_count = acc_count + 1;
      advance_rotation();
      if (acc_count >= zrac_pkg::GROUP_DIGITS || l) begin
        v = acc_value;
        for (c = acc_count; c < zrac_pkg::GROUP_DIGITS; c++) v = v * 32'd85;
        for (j = 0; j < zrac_pkg::GROUP_BYTES; j++) begin
          r.out_byte = v[8*(zrac_pkg::GROUP_BYTES-1-j) +: 8];
          r.out_last = (j == zrac_pkg::GROUP_BYTES - 1);
          r.bad_char = acc_bad;
          if (keep) owed_codes.push_back(r);
        end
        drop_group();
      end
    end
    if (l) begin
      drop_group();
      rot_offset = 0;
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic l, input bit keep);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_chan.valid   <= 1'b1;
    item_chan.in_byte <= b;
    item_chan.in_last <= l;
    @(posedge clk);
    while (!item_chan.ready) @(posedge clk);
    z85_translate(b, l, keep);
    items_sent++;
  endtask

  // Hold the source idle until every owed result is back, then let the block settle.
  task automatic settle_idle();
    item_chan.valid <= 1'b0;
    while (owed_codes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input bit set_mode, input zrac_pkg::mode_t m, input bit set_step,
                           input logic [6:0] s);
    if (set_mode) begin
      wr_en    <= 1'b1;
      wr_index <= zrac_pkg::REG_MODE;
      wr_data  <= zrac_pkg::CFG_DATA_W'(m);
      @(posedge clk);
      cur_mode = m;
      drop_group();
    end
    if (set_step) begin
      wr_en    <= 1'b1;
      wr_index <= zrac_pkg::REG_STEP;
      wr_data  <= s;
      @(posedge clk);
      cur_step = s;
    end
    wr_en <= 1'b0;
  endtask

  initial begin
    codec_out_t got;
    codec_out_t want;
    int         stall_left;
    int         hold_left;
    stall_left = 0;
    hold_left  = 0;
    result_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_chan.valid && result_chan.ready) begin
        got.out_byte = result_chan.out_byte;
        got.out_last = result_chan.out_last;
        got.bad_char = result_chan.bad_char;
        if (owed_codes.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: byte %h last %b bad %b",
                     got.out_byte, got.out_last, got.bad_char);
        end else begin
          want = owed_codes.pop_front();
          if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
              got.bad_char !== want.bad_char) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: expected byte %h last %b bad %b, got byte %h last %b bad %b",
                       want.out_byte, want.out_last, want.bad_char,
                       got.out_byte, got.out_last, got.bad_char);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_chan.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        result_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_chan.ready <= 1'b0;
      end else begin
        result_chan.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int              row;
    int              k;
    int              phase;
    int              phase_len;
    logic [7:0]      b;
    bit              set_mode;
    bit              set_step;
    zrac_pkg::mode_t m;
    logic [6:0]      s;
    codec_out_t      typed_out;

    rst               <= 1'b1;
    wr_en             <= 1'b0;
    wr_index          <= zrac_pkg::REG_MODE;
    wr_data           <= '0;
    item_chan.valid   <= 1'b0;
    item_chan.in_byte <= '0;
    item_chan.in_last <= 1'b0;
    failures      = 0;
    items_sent    = 0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    cur_mode      = zrac_pkg::MODE_ENCODE;
    cur_step      = '0;
    rot_offset    = 0;
    drop_group();

    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (row = 0; row < PLAN_LEN; row++) begin
      case (PLAN[row].kind)
        ROW_SET_MODE: begin
          settle_idle();
          configure(1'b1, zrac_pkg::mode_t'(PLAN[row].val[0]), 1'b0, 7'd0);
        end
        ROW_SET_STEP: begin
          settle_idle();
          configure(1'b0, zrac_pkg::MODE_ENCODE, 1'b1, PLAN[row].val[6:0]);
        end
        default: begin
          send_item(PLAN[row].val, PLAN[row].last, PLAN[row].n_known == 3'd0);
          for (k = 0; k < int'(PLAN[row].n_known); k++) begin
            typed_out.out_byte = PLAN[row].known[8*(int'(PLAN[row].n_known)-1-k) +: 8];
            typed_out.out_last = (k == int'(PLAN[row].n_known) - 1);
            typed_out.bad_char = PLAN[row].known_bad;
            owed_codes.push_back(typed_out);
          end
        end
      endcase
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle_idle();
      quiet = (phase % 4 == 1);
      set_mode = ($urandom_range(0, 9) < 7);
      set_step = ($urandom_range(0, 9) < 8);
      m = zrac_pkg::mode_t'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0: s = 7'd0;
        1: s = 7'd84;
        2: s = 7'd85;
        3: s = 7'd127;
        default: s = 7'($urandom_range(0, 127));
      endcase
      configure(set_mode, m, set_step, s);
      if (phase == 2) long_hold_req = 1'b1;
      phase_len = (phase == 2) ? LONG_PHASE : $urandom_range(15, 50);
      for (k = 0; k < phase_len; k++) begin
        if (cur_mode == zrac_pkg::MODE_DECODE && $urandom_range(0, 99) < 88)
          b = z85_char($urandom_range(0, zrac_pkg::RADIX - 1));
        else
          b = 8'($urandom_range(0, 255));
        send_item(b, $urandom_range(0, 11) == 0, 1'b1);
      end
      phase++;
    end

    settle_idle();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
